@@ rtl/core/xcfp_pkg.sv @@
// Shared types and constants for the XOR-checked frame parser.
package xcfp_pkg;

  localparam logic [7:0] SYNC_FIRST     = 8'hAA;
  localparam logic [7:0] SYNC_SECOND    = 8'hBB;
  localparam int         FRAME_OVERHEAD = 7;
  localparam int         HDR_BYTES      = 6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_SYNC     = 3'd2;
  localparam logic [2:0] ST_OVERLONG = 3'd3;
  localparam logic [2:0] ST_LEN      = 3'd4;
  localparam logic [2:0] ST_CSUM     = 3'd5;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_frame;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] source_addr;
    logic [7:0] dest_addr;
    logic [7:0] command_code;
    logic [5:0] payload_count;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       last_result;
  } out_t;

  // One checked frame handed from intake to release
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] cmd;
    logic [7:0] len;
    logic       bank;
  } job_t;

  // Payload buffer write port
  typedef struct packed {
    logic       en;
    logic       bank;
    logic [7:0] idx;
    logic [7:0] data;
  } mem_wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SEND
  } bk_state_t;

endpackage

@@ rtl/core/xcfp_front.sv @@
// Frame intake: byte counting, sync and checksum tracking, header capture, frame check.
module xcfp_front import xcfp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  in_t     in_data,
  input  logic    q_full,
  output logic    job_push,
  output job_t    job,
  output mem_wr_t wr
);

  localparam int CW  = $clog2(MAX_FRAME_BYTES + 2);
  localparam int LIM = MAX_FRAME_BYTES + 1;
  localparam int CAP = MAX_FRAME_BYTES - FRAME_OVERHEAD;

  logic [CW-1:0] byte_count_r;
  logic [7:0]    running_xor_r;
  logic          sync_ok_r;
  logic [7:0]    src_hold_r, dst_hold_r, cmd_hold_r, length_hold_r;
  logic          wr_bank_r;

  logic          accept;
  logic [7:0]    b;
  logic          eof;
  logic          sync_now;
  logic [8:0]    len9;
  logic [2:0]    status;
  logic [CW-1:0] pay_pos;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.byte_in;
  assign eof      = in_data.end_of_frame;
  assign pay_pos  = byte_count_r - CW'(HDR_BYTES);

  always_comb begin
    sync_now = sync_ok_r;
    if (byte_count_r == CW'(0) && b != SYNC_FIRST) sync_now = 1'b0;
    if (byte_count_r == CW'(1) && b != SYNC_SECOND) sync_now = 1'b0;
    if (9'(byte_count_r) >= 9'(LIM)) len9 = 9'(LIM);
    else len9 = 9'(byte_count_r) + 9'd1;
    if (len9 < 9'(FRAME_OVERHEAD)) status = ST_SHORT;
    else if (!sync_now) status = ST_SYNC;
    else if (len9 > 9'(MAX_FRAME_BYTES)) status = ST_OVERLONG;
    else if (9'(length_hold_r) != len9 - 9'(FRAME_OVERHEAD)) status = ST_LEN;
    else if (running_xor_r != b) status = ST_CSUM;
    else status = ST_OK;
  end

  assign job_push = accept && eof;
  assign job = '{status: status, src: src_hold_r, dst: dst_hold_r, cmd: cmd_hold_r,
                 len: length_hold_r, bank: wr_bank_r};

  assign wr.en   = accept && !eof && (byte_count_r >= CW'(HDR_BYTES)) &&
                   (pay_pos < CW'(CAP));
  assign wr.bank = wr_bank_r;
  assign wr.idx  = 8'(pay_pos);
  assign wr.data = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      running_xor_r <= '0;
      sync_ok_r     <= 1'b1;
      src_hold_r    <= '0;
      dst_hold_r    <= '0;
      cmd_hold_r    <= '0;
      length_hold_r <= '0;
      wr_bank_r     <= 1'b0;
    end else if (accept) begin
      if (eof) begin
        byte_count_r  <= '0;
        running_xor_r <= '0;
        sync_ok_r     <= 1'b1;
        wr_bank_r     <= !wr_bank_r;
      end else begin
        sync_ok_r <= sync_now;
        if (byte_count_r == CW'(2)) src_hold_r <= b;
        if (byte_count_r == CW'(3)) dst_hold_r <= b;
        if (byte_count_r == CW'(4)) cmd_hold_r <= b;
        if (byte_count_r == CW'(5)) length_hold_r <= b;
        if (byte_count_r >= CW'(2)) running_xor_r <= running_xor_r ^ b;
        if (byte_count_r < CW'(LIM)) byte_count_r <= byte_count_r + CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/xcfp_job_q.sv @@
// Two-entry queue of checked frames between intake and release.
module xcfp_job_q import xcfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  job_t       entries_r [0:1];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule

@@ rtl/core/xcfp_back.sv @@
// Result release: two-bank payload buffer and the output register.
module xcfp_back import xcfp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic    clk,
  input  logic    rst_n,
  input  mem_wr_t wr,
  input  logic    job_valid,
  input  job_t    job,
  output logic    job_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output out_t    out_data
);

  localparam int CAP = MAX_FRAME_BYTES - FRAME_OVERHEAD;
  localparam int IW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int AW  = IW + 1;

  logic [7:0]    mem_r [0:(2**AW)-1];
  bk_state_t     state_r, state_nxt;
  logic [IW-1:0] idx_r;
  out_t          out_data_r;
  logic          out_valid_r;

  logic          single;
  logic          load_single, start_fetch, load_byte, sent, next_idx;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  assign single  = (job.status != ST_OK) || (job.len == 8'd0);
  assign rd_addr = {job.bank, idx_r};
  assign wr_addr = {wr.bank, wr.idx[IW-1:0]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (job_valid) state_nxt = single ? BK_SEND : BK_FETCH;
      end
      BK_FETCH: state_nxt = BK_SEND;
      BK_SEND: begin
        if (out_ready) state_nxt = out_data_r.last_result ? BK_IDLE : BK_FETCH;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    load_single = 1'b0;
    start_fetch = 1'b0;
    load_byte   = 1'b0;
    sent        = 1'b0;
    case (state_r)
      BK_IDLE: begin
        load_single = job_valid && single;
        start_fetch = job_valid && !single;
      end
      BK_FETCH: load_byte = 1'b1;
      BK_SEND:  sent = out_ready;
      default: ;
    endcase
    job_pop  = sent && out_data_r.last_result;
    next_idx = sent && !out_data_r.last_result;
  end

  always_ff @(posedge clk) begin
    if (wr.en) mem_r[wr_addr] <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (load_single) begin
      out_data_r.status        <= job.status;
      out_data_r.source_addr   <= (job.status == ST_OK) ? job.src : 8'd0;
      out_data_r.dest_addr     <= (job.status == ST_OK) ? job.dst : 8'd0;
      out_data_r.command_code  <= (job.status == ST_OK) ? job.cmd : 8'd0;
      out_data_r.payload_count <= '0;
      out_data_r.payload_byte  <= '0;
      out_data_r.payload_valid <= 1'b0;
      out_data_r.last_result   <= 1'b1;
    end else if (load_byte) begin
      out_data_r.status        <= ST_OK;
      out_data_r.source_addr   <= job.src;
      out_data_r.dest_addr     <= job.dst;
      out_data_r.command_code  <= job.cmd;
      out_data_r.payload_count <= job.len[5:0];
      out_data_r.payload_byte  <= mem_r[rd_addr];
      out_data_r.payload_valid <= 1'b1;
      out_data_r.last_result   <= (9'(idx_r) + 9'd1 == 9'(job.len));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start_fetch) idx_r <= '0;
      else if (next_idx) idx_r <= idx_r + IW'(1);
      if (load_single || load_byte) out_valid_r <= 1'b1;
      else if (sent) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/xor_checked_frame_parser.sv @@
// Sync-header frame parser with XOR checksum: top level.
// Intake takes one byte per cycle; it stalls only while two checked frames await release.
// A failed or empty frame yields a single result, registered once its job heads the queue.
// Payload bytes leave one at a time: a buffer read, then the output register; the next
// byte is fetched only after the previous one transfers, so out_ready low holds the flow.
// Reset (rst_n low, synchronous) empties the queue, drops any result in flight and restarts intake.
module xor_checked_frame_parser import xcfp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Intake side: classify each frame on its final byte and push one job.
  // The payload goes into the bank the intake currently owns; banks alternate per frame.
  logic    q_full;
  logic    job_push;
  job_t    push_job;
  mem_wr_t wr;

  // Release side: the head job owns the other bank until its last result transfers.
  logic    head_valid;
  job_t    head_job;
  logic    job_pop;

  xcfp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .job_push (job_push),
    .job      (push_job),
    .wr       (wr)
  );

  // Two entries match the two payload banks, so a full queue means no free bank:
  // hold intake until release drops the oldest frame.
  xcfp_job_q u_job_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (push_job),
    .pop        (job_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Walk the head job's payload and advance on each output transfer.
  xcfp_back #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .job_valid (head_valid),
    .job       (head_job),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/xcfp_checker.sv @@
// Port-level checks for the frame parser, bound to the top level.
module xcfp_checker import xcfp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_CSUM)
    else $error("status code out of range");

  a_fail_bare: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      !out_data.payload_valid && out_data.last_result &&
      out_data.source_addr == 8'd0 && out_data.dest_addr == 8'd0 &&
      out_data.command_code == 8'd0 && out_data.payload_byte == 8'd0)
    else $error("failed frame result carries data");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.payload_valid |->
      out_data.last_result && out_data.payload_count == 6'd0)
    else $error("result without payload is not final");

endmodule

bind xor_checked_frame_parser xcfp_checker u_xcfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the XOR-checked frame parser: directed and random frames.
`timescale 1ns / 1ps

module tb_top;
  import xcfp_pkg::*;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int PAYLOAD_CAP     = MAX_FRAME_BYTES - FRAME_OVERHEAD;
  // Header byte offsets; the checksum covers everything from POS_SRC on
  localparam int POS_SRC = 2;
  localparam int POS_DST = 3;
  localparam int POS_CMD = 4;
  localparam int POS_LEN = 5;
  localparam int RANDOM_BYTES = 85;

  typedef logic [7:0] byte_q_t[$];

  // Kinds of frame the stimulus builds
  typedef enum int {
    FR_GOOD,
    FR_BAD_CSUM,
    FR_BAD_LEN,
    FR_BAD_SYNC,
    FR_SHORT,
    FR_OVERLONG,
    FR_NOISE
  } frame_kind_e;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  // Frame tracker state, mirrors what the parser holds between bytes
  int         frame_pos = 0;
  logic [7:0] xor_acc   = '0;
  logic       sync_good = 1'b1;
  logic [7:0] hdr_src   = '0;
  logic [7:0] hdr_dst   = '0;
  logic [7:0] hdr_cmd   = '0;
  logic [7:0] hdr_len   = '0;
  logic [7:0] payload_buf [PAYLOAD_CAP];

  out_t awaited_results[$];
  out_t head_result;
  int   fail_count   = 0;
  int   bytes_sent   = 0;
  int   tx_gap_pct   = 0;
  int   rx_stall_pct = 0;
  int   stall_left   = 0;

  xor_checked_frame_parser #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5ms;
    $display("tb_top: FAIL");
    $finish;
  end

  // Update the frame tracker with one accepted byte; on the final byte,
  // check the frame and queue the results it must produce.
  task automatic track_byte(input in_t item);
    int         pos;
    int         flen;
    logic [2:0] code;
    out_t       r;
    pos = frame_pos;
    if (pos == 0 && item.byte_in != SYNC_FIRST) sync_good = 1'b0;
    if (pos == 1 && item.byte_in != SYNC_SECOND) sync_good = 1'b0;
    if (!item.end_of_frame) begin
      if (pos == POS_SRC) hdr_src = item.byte_in;
      if (pos == POS_DST) hdr_dst = item.byte_in;
      if (pos == POS_CMD) hdr_cmd = item.byte_in;
      if (pos == POS_LEN) hdr_len = item.byte_in;
      if (pos >= HDR_BYTES && pos - HDR_BYTES < PAYLOAD_CAP)
        payload_buf[pos - HDR_BYTES] = item.byte_in;
      if (pos >= POS_SRC) xor_acc ^= item.byte_in;
      // Byte counter saturates one past the frame limit
      if (frame_pos < MAX_FRAME_BYTES + 1) frame_pos++;
    end else begin
      flen = (pos + 1 > MAX_FRAME_BYTES + 1) ? MAX_FRAME_BYTES + 1 : pos + 1;
      if (flen < FRAME_OVERHEAD) code = ST_SHORT;
      else if (!sync_good) code = ST_SYNC;
      else if (flen > MAX_FRAME_BYTES) code = ST_OVERLONG;
      else if (int'(hdr_len) != flen - FRAME_OVERHEAD) code = ST_LEN;
      else if (xor_acc != item.byte_in) code = ST_CSUM;
      else code = ST_OK;

      if (code != ST_OK) begin
        // Failed frame: a lone status result, no header fields
        r = '0;
        r.status = code;
        r.last_result = 1'b1;
        awaited_results.push_back(r);
      end else if (hdr_len == 8'd0) begin
        // Empty payload: header fields only
        r = '0;
        r.source_addr  = hdr_src;
        r.dest_addr    = hdr_dst;
        r.command_code = hdr_cmd;
        r.last_result  = 1'b1;
        awaited_results.push_back(r);
      end else begin
        for (int i = 0; i < int'(hdr_len) && i < PAYLOAD_CAP; i++) begin
          r = '0;
          r.status        = ST_OK;
          r.source_addr   = hdr_src;
          r.dest_addr     = hdr_dst;
          r.command_code  = hdr_cmd;
          r.payload_count = hdr_len[5:0];
          r.payload_byte  = payload_buf[i];
          r.payload_valid = 1'b1;
          r.last_result   = (i + 1 == int'(hdr_len));
          awaited_results.push_back(r);
        end
      end
      frame_pos = 0;
      xor_acc   = '0;
      sync_good = 1'b1;
    end
  endtask

  // Offer one byte, with an optional random gap first, and hold it until
  // the transfer happens. Called and returns at a rising edge.
  task automatic send_byte(input logic [7:0] value, input logic last);
    in_t item;
    item.byte_in      = value;
    item.end_of_frame = last;
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    track_byte(item);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_q_t fr);
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
  endtask

  // Assemble a frame of the given kind. Header fields apply to the kinds
  // that carry a header; payload content is random.
  task automatic build_frame(input frame_kind_e kind, input logic [7:0] src,
                             input logic [7:0] dst, input logic [7:0] cmd,
                             input int n_pay, output byte_q_t fr);
    logic [7:0] csum;
    fr = {};
    case (kind)
      FR_SHORT: begin
        // Half the time start with the sync pair so only the length is wrong
        if ($urandom_range(0, 1)) begin
          fr.push_back(SYNC_FIRST);
          fr.push_back(SYNC_SECOND);
          repeat ($urandom_range(0, FRAME_OVERHEAD - 3)) fr.push_back(8'($urandom));
        end else begin
          repeat ($urandom_range(1, FRAME_OVERHEAD - 1)) fr.push_back(8'($urandom));
        end
      end
      FR_NOISE: begin
        repeat ($urandom_range(1, 24)) fr.push_back(8'($urandom));
      end
      FR_OVERLONG: begin
        // Good sync so the length check is what trips; run to or past saturation
        fr.push_back(SYNC_FIRST);
        fr.push_back(SYNC_SECOND);
        repeat ($urandom_range(MAX_FRAME_BYTES - 1, MAX_FRAME_BYTES + 6))
          fr.push_back(8'($urandom));
      end
      default: begin
        fr.push_back(SYNC_FIRST);
        fr.push_back(SYNC_SECOND);
        fr.push_back(src);
        fr.push_back(dst);
        fr.push_back(cmd);
        fr.push_back(8'(n_pay));
        repeat (n_pay) fr.push_back(8'($urandom));
        // Nonzero offset keeps the length field wrong after 8-bit wrap
        if (kind == FR_BAD_LEN) fr[POS_LEN] = fr[POS_LEN] + 8'($urandom_range(1, 255));
        csum = '0;
        for (int i = POS_SRC; i < fr.size(); i++) csum ^= fr[i];
        if (kind == FR_BAD_CSUM) csum ^= 8'($urandom_range(1, 255));
        fr.push_back(csum);
        if (kind == FR_BAD_SYNC) fr[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      end
    endcase
  endtask

  task automatic send_random_frame(input frame_kind_e kind, input int n_pay);
    byte_q_t fr;
    build_frame(kind, 8'($urandom), 8'($urandom), 8'($urandom), n_pay, fr);
    send_frame(fr);
  endtask

  // Receiver: ready high except for random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Compare every result transfer with the oldest outstanding expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
        fail_count++;
      end else begin
        head_result = awaited_results.pop_front();
        check_field("status",        8'(head_result.status),        8'(out_data.status));
        check_field("source_addr",   head_result.source_addr,       out_data.source_addr);
        check_field("dest_addr",     head_result.dest_addr,         out_data.dest_addr);
        check_field("command_code",  head_result.command_code,      out_data.command_code);
        check_field("payload_count", 8'(head_result.payload_count), 8'(out_data.payload_count));
        check_field("payload_byte",  head_result.payload_byte,      out_data.payload_byte);
        check_field("payload_valid", 8'(head_result.payload_valid), 8'(out_data.payload_valid));
        check_field("last_result",   8'(head_result.last_result),   8'(out_data.last_result));
      end
    end
  end

  // Too short: eof on the very first byte, and a six-byte frame with a
  // plausible header
  task automatic test_short_frames();
    byte_q_t fr;
    fr = {SYNC_FIRST};
    send_frame(fr);
    fr = {SYNC_FIRST, SYNC_SECOND, 8'h01, 8'h02, 8'h03, 8'h00};
    send_frame(fr);
  endtask

  // Bad sync on either sync byte, otherwise well-formed
  task automatic test_bad_sync();
    byte_q_t fr;
    build_frame(FR_GOOD, 8'h11, 8'h22, 8'h33, 2, fr);
    fr[0] = 8'h00;
    send_frame(fr);
    build_frame(FR_GOOD, 8'h44, 8'h55, 8'h66, 1, fr);
    fr[1] = SYNC_FIRST;
    send_frame(fr);
  endtask

  // Overlong: exactly one byte past the limit, then one to eight bytes past it
  task automatic test_overlong();
    byte_q_t fr;
    fr = {SYNC_FIRST, SYNC_SECOND};
    repeat (MAX_FRAME_BYTES - 1) fr.push_back(8'($urandom));
    send_frame(fr);
    send_random_frame(FR_OVERLONG, 0);
  endtask

  // Length mismatch with the largest length field, then bad checksum
  task automatic test_length_and_checksum();
    byte_q_t fr;
    build_frame(FR_GOOD, 8'h5A, 8'hA5, 8'h0F, 1, fr);
    fr[POS_LEN] = 8'hFF;
    fr[fr.size() - 1] ^= 8'hFF ^ 8'h01;  // keep the checksum right
    send_frame(fr);
    build_frame(FR_BAD_CSUM, 8'h01, 8'h02, 8'h03, 3, fr);
    send_frame(fr);
  endtask

  // Valid frames at the header and payload extremes
  task automatic test_valid_extremes();
    byte_q_t fr;
    build_frame(FR_GOOD, 8'h00, 8'hFF, 8'h00, 0, fr);
    send_frame(fr);
    build_frame(FR_GOOD, 8'hFF, 8'h00, 8'hFF, 0, fr);
    send_frame(fr);
    build_frame(FR_GOOD, 8'hFF, 8'hFF, 8'hFF, PAYLOAD_CAP, fr);
    for (int i = HDR_BYTES; i < fr.size() - 1; i++) fr[i] = (i % 2) ? 8'hFF : 8'h00;
    fr[fr.size() - 1] = '0;
    for (int i = POS_SRC; i < fr.size() - 1; i++) fr[fr.size() - 1] ^= fr[i];
    send_frame(fr);
    build_frame(FR_GOOD, 8'h00, 8'h00, 8'h00, 1, fr);
    send_frame(fr);
  endtask

  // Hold off the sender until every queued result has drained, then resume
  task automatic test_drain_pause();
    send_random_frame(FR_GOOD, 5);
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
    send_random_frame(FR_GOOD, 3);
  endtask

  // Mostly well-formed frames with random content, plus corrupt frames and
  // noise; the idle profile changes every few frames.
  task automatic test_random_traffic();
    int          start;
    int          frames;
    int          pick;
    int          n_pay;
    frame_kind_e kind;
    start  = bytes_sent;
    frames = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (frames % 8 == 0) begin
        case ($urandom_range(0, 3))
          0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
          1: begin tx_gap_pct = 10; rx_stall_pct = 10; end
          2: begin tx_gap_pct = 2;  rx_stall_pct = 40; end
          default: begin tx_gap_pct = 30; rx_stall_pct = 5; end
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) kind = FR_GOOD;
      else if (pick < 72) kind = FR_BAD_CSUM;
      else if (pick < 79) kind = FR_BAD_LEN;
      else if (pick < 85) kind = FR_BAD_SYNC;
      else if (pick < 90) kind = FR_SHORT;
      else if (pick < 94) kind = FR_OVERLONG;
      else kind = FR_NOISE;
      // Keep most payloads short; now and then go up to the buffer size
      n_pay = ($urandom_range(0, 9) == 0) ? $urandom_range(0, PAYLOAD_CAP)
                                          : $urandom_range(0, 6);
      send_random_frame(kind, n_pay);
      frames++;
    end
  endtask

  // Final stretch with both sides running flat out
  task automatic test_calm_tail();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    repeat (6) send_random_frame(FR_GOOD, $urandom_range(0, 8));
    send_random_frame(FR_BAD_CSUM, 2);
    send_random_frame(FR_GOOD, 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_frames();
    test_bad_sync();
    test_overlong();
    test_length_and_checksum();
    test_valid_extremes();
    tx_gap_pct   = 15;
    rx_stall_pct = 15;
    test_drain_pause();
    test_random_traffic();
    test_calm_tail();

    // Drop valid after the last transfer, drain, then let the pipe settle
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/xcfp_pkg.sv
rtl/core/xcfp_front.sv
rtl/core/xcfp_job_q.sv
rtl/core/xcfp_back.sv
rtl/core/xor_checked_frame_parser.sv
rtl/core/xcfp_checker.sv
tb/tb_top.sv
